[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the slice extractor.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define OSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define OSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/ose_pkg.sv]
// Package for the orthogonal slice extractor: plane codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ose_pkg;

  typedef enum logic [1:0] {
    PLANE_YZ = 2'd0,
    PLANE_XZ = 2'd1,
    PLANE_XY = 2'd2
  } plane_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CFG_SIZE_X    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_Y    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_Z    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLICE_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLICE_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLICE_Z   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FLIP_MASK = 3'd6;

  localparam logic [CfgDataW-1:0] SIZE_RESET = 9'd256;

endpackage

`default_nettype wire

[rtl/core/orthogonal_slice_extractor_unit.sv]
// Orthogonal slice extractor: top level, input register, index math, result register.
// Depends on ose_pkg and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o, voxel_bits_i): one voxel per beat in
//    raster order, x fastest, then y, then z. Position counters wrap after the
//    last voxel of the volume.
//  - Output channel (out_valid_o/out_ready_i): one beat per plane hit, in order
//    yz, xz, xy; last_o marks the final beat caused by a voxel. Voxels on no
//    selected plane produce nothing.
//  - Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): always
//    ready; write only while idle. Writing a size clears the position counters.
//  - Path: a voxel passes the input register, then the result register offers its results.
//  - Throughput: one voxel per cycle while each voxel hits at most one plane and the
//    output is not stalled; a voxel hitting k planes holds the result register until
//    all k beats are taken, setting the input rate through the one-entry input register.
//  - Reset: sizes 256 (clamped to MAX_DIM), slices 0, no flips, counters at the
//    origin, both pipeline registers empty.
//  - Output stall: results hold in the result register; voxels on no plane keep
//    flowing, the first one that hits waits in the input register, in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module orthogonal_slice_extractor_unit
  import ose_pkg::*;
#(
  parameter int unsigned MAX_DIM = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [31:0]         voxel_bits_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               plane_o,
  output logic [15:0]              plane_index_o,
  output logic [31:0]              value_out_o,
  output logic                     last_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned SW = $clog2(MAX_DIM + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;
  localparam int unsigned IW = ((CW + SW + 1) > 16) ? (CW + SW + 1) : 16;

  function automatic logic [SW-1:0] eff_size(input logic [CfgDataW-1:0] s);
    logic [SW-1:0] r;
    begin
      if (s == '0) r = SW'(1);
      else if (32'(s) > MAX_DIM) r = SW'(MAX_DIM);
      else r = SW'(s);
      return r;
    end
  endfunction

  function automatic logic [CW-1:0] mirror(input logic [CW-1:0] c,
                                           input logic [SW-1:0] n,
                                           input logic rev);
    logic [SW-1:0] t;
    begin
      t = n - SW'(1) - SW'(c);
      return rev ? t[CW-1:0] : c;
    end
  endfunction

  // configuration
  logic [CfgDataW-1:0] size_x_q, size_y_q, size_z_q;
  logic [7:0]          slice_x_q, slice_y_q, slice_z_q;
  logic [2:0]          flip_q;
  logic                cfg_acc, size_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign size_wr     = cfg_acc && ((cfg_index_i == CFG_SIZE_X) ||
                                   (cfg_index_i == CFG_SIZE_Y) ||
                                   (cfg_index_i == CFG_SIZE_Z));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= SIZE_RESET;
      size_y_q  <= SIZE_RESET;
      size_z_q  <= SIZE_RESET;
      slice_x_q <= '0;
      slice_y_q <= '0;
      slice_z_q <= '0;
      flip_q    <= '0;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_SIZE_X:    size_x_q  <= cfg_data_i;
        CFG_SIZE_Y:    size_y_q  <= cfg_data_i;
        CFG_SIZE_Z:    size_z_q  <= cfg_data_i;
        CFG_SLICE_X:   slice_x_q <= cfg_data_i[7:0];
        CFG_SLICE_Y:   slice_y_q <= cfg_data_i[7:0];
        CFG_SLICE_Z:   slice_z_q <= cfg_data_i[7:0];
        CFG_FLIP_MASK: flip_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] sx, sy, sz;
  assign sx = eff_size(size_x_q);
  assign sy = eff_size(size_y_q);
  assign sz = eff_size(size_z_q);

  // position counters
  logic [CW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic [CW-1:0] xc, yc, zc;
  logic          in_acc;

  assign in_acc = in_valid_i && in_ready_o;
  assign xc = (SW'(x_q) >= sx) ? '0 : x_q;
  assign yc = (SW'(y_q) >= sy) ? '0 : y_q;
  assign zc = (SW'(z_q) >= sz) ? '0 : z_q;

  always_comb begin
    x_d = xc;
    y_d = yc;
    z_d = zc;
    if ((SW'(xc) + SW'(1)) >= sx) begin
      x_d = '0;
      if ((SW'(yc) + SW'(1)) >= sy) begin
        y_d = '0;
        z_d = ((SW'(zc) + SW'(1)) >= sz) ? '0 : zc + CW'(1);
      end else begin
        y_d = yc + CW'(1);
      end
    end else begin
      x_d = xc + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (size_wr) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (in_acc) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // input register
  logic          s1_valid_q;
  logic [CW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [31:0]   s1_val_q;
  logic [2:0]    s1_hit;
  logic          s1_adv, s2_free, s2_load;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q   <= xc;
      s1_y_q   <= yc;
      s1_z_q   <= zc;
      s1_val_q <= voxel_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  assign s1_hit[0] = XW'(s1_x_q) == XW'(slice_x_q);
  assign s1_hit[1] = XW'(s1_y_q) == XW'(slice_y_q);
  assign s1_hit[2] = XW'(s1_z_q) == XW'(slice_z_q);

  assign s1_adv     = s1_valid_q && ((s1_hit == '0) || s2_free);
  assign s2_load    = s1_valid_q && (s1_hit != '0) && s2_free;
  assign in_ready_o = !s1_valid_q || s1_adv;

  logic [CW-1:0] mx, my, mz, myxy;
  logic [IW-1:0] idx_yz, idx_xz, idx_xy;

  assign mx   = mirror(s1_x_q, sx, flip_q[0]);
  assign my   = mirror(s1_y_q, sy, flip_q[1]);
  assign myxy = mirror(s1_y_q, sy, !flip_q[1]);
  assign mz   = mirror(s1_z_q, sz, flip_q[2]);

  assign idx_yz = IW'(my) + IW'(mz) * IW'(sy);
  assign idx_xz = IW'(mx) + IW'(mz) * IW'(sx);
  assign idx_xy = IW'(mx) + IW'(myxy) * IW'(sx);

  // result register
  logic [2:0]  s2_mask_q, s2_mask_d, s2_pick, s2_rest;
  logic [15:0] s2_yz_q, s2_xz_q, s2_xy_q;
  logic [31:0] s2_val_q;
  logic        out_acc;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_yz_q  <= idx_yz[15:0];
      s2_xz_q  <= idx_xz[15:0];
      s2_xy_q  <= idx_xy[15:0];
      s2_val_q <= s1_val_q;
    end
  end

  always_comb begin
    if (s2_mask_q[0])      s2_pick = 3'b001;
    else if (s2_mask_q[1]) s2_pick = 3'b010;
    else                   s2_pick = s2_mask_q & 3'b100;
  end

  assign s2_rest = s2_mask_q & ~s2_pick;
  assign out_acc = out_valid_o && out_ready_i;
  assign s2_free = (s2_mask_q == '0) || (out_acc && (s2_rest == '0));

  always_comb begin
    s2_mask_d = s2_mask_q;
    if (s2_load)      s2_mask_d = s1_hit;
    else if (out_acc) s2_mask_d = s2_rest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_mask_q <= '0;
    else         s2_mask_q <= s2_mask_d;
  end

  always_comb begin
    if (s2_mask_q[0]) begin
      plane_o       = PLANE_YZ;
      plane_index_o = s2_yz_q;
    end else if (s2_mask_q[1]) begin
      plane_o       = PLANE_XZ;
      plane_index_o = s2_xz_q;
    end else begin
      plane_o       = PLANE_XY;
      plane_index_o = s2_xy_q;
    end
  end

  assign out_valid_o = s2_mask_q != '0;
  assign value_out_o = s2_val_q;
  assign last_o      = s2_rest == '0;

  `OSE_ASSERT(a_last_single, clk_i, rst_ni, (out_valid_o && last_o) |-> $onehot(s2_mask_q))
  `OSE_ASSERT(a_more_pending, clk_i, rst_ni, (out_acc && !last_o) |=> out_valid_o)
  `OSE_ASSERT(a_stall_has_item, clk_i, rst_ni, !in_ready_o |-> (s1_valid_q && out_valid_o))
  `OSE_ASSERT(a_size_clears_pos, clk_i, rst_ni,
    size_wr |=> ((x_q == '0) && (y_q == '0) && (z_q == '0)))

endmodule

`default_nettype wire

[bench/tb_orthogonal_slice_extractor_unit.sv]
// Testbench for orthogonal_slice_extractor_unit: streams voxels through random volume setups,
// predicts every plane beat in a scoreboard class and checks each output beat against it.
// Depends on ose_pkg and the RTL of the slice extractor.
`timescale 1ns / 1ps

module tb_orthogonal_slice_extractor_unit;
  import ose_pkg::*;

  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned TOTAL_VOXELS = 410;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    plane_e      plane;
    logic [15:0] index;
    logic [31:0] value;
    logic        last;
  } plane_beat_t;

  class slice_tracker;
    logic [8:0]  dim_x, dim_y, dim_z;
    logic [7:0]  cut_x, cut_y, cut_z;
    logic [2:0]  flips;
    int unsigned px, py, pz;
    plane_beat_t pending_hits[$];
    int unsigned errors;

    function new();
      dim_x = SIZE_RESET;
      dim_y = SIZE_RESET;
      dim_z = SIZE_RESET;
      cut_x = '0;
      cut_y = '0;
      cut_z = '0;
      flips = '0;
      px = 0;
      py = 0;
      pz = 0;
      errors = 0;
    endfunction

    function int unsigned span(logic [8:0] s);
      if (s == 0) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
    endfunction

    function int unsigned reflect(int unsigned c, int unsigned n, bit rev);
      return rev ? n - 1 - c : c;
    endfunction

    function int unsigned pending();
      return pending_hits.size();
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SIZE_X:    dim_x = data;
        CFG_SIZE_Y:    dim_y = data;
        CFG_SIZE_Z:    dim_z = data;
        CFG_SLICE_X:   cut_x = data[7:0];
        CFG_SLICE_Y:   cut_y = data[7:0];
        CFG_SLICE_Z:   cut_z = data[7:0];
        CFG_FLIP_MASK: flips = data[2:0];
        default: ;
      endcase
      if (idx == CFG_SIZE_X || idx == CFG_SIZE_Y || idx == CFG_SIZE_Z) begin
        px = 0;
        py = 0;
        pz = 0;
      end
    endfunction

    function void take_voxel(logic [31:0] bits);
      int unsigned sx, sy, sz, x, y, z;
      bit hit_yz, hit_xz, hit_xy;
      plane_beat_t b;
      sx = span(dim_x);
      sy = span(dim_y);
      sz = span(dim_z);
      x = (px >= sx) ? 0 : px;
      y = (py >= sy) ? 0 : py;
      z = (pz >= sz) ? 0 : pz;
      hit_yz = (x == cut_x);
      hit_xz = (y == cut_y);
      hit_xy = (z == cut_z);
      b.value = bits;
      if (hit_yz) begin
        b.plane = PLANE_YZ;
        b.index = 16'(reflect(y, sy, flips[1]) + reflect(z, sz, flips[2]) * sy);
        b.last  = !(hit_xz || hit_xy);
        pending_hits.push_back(b);
      end
      if (hit_xz) begin
        b.plane = PLANE_XZ;
        b.index = 16'(reflect(x, sx, flips[0]) + reflect(z, sz, flips[2]) * sx);
        b.last  = !hit_xy;
        pending_hits.push_back(b);
      end
      if (hit_xy) begin
        // xy plane runs y upside down unless the y flip is set
        b.plane = PLANE_XY;
        b.index = 16'(reflect(x, sx, flips[0]) + reflect(y, sy, !flips[1]) * sx);
        b.last  = 1'b1;
        pending_hits.push_back(b);
      end
      if (x + 1 >= sx) begin
        x = 0;
        if (y + 1 >= sy) begin
          y = 0;
          z = (z + 1 >= sz) ? 0 : z + 1;
        end else begin
          y++;
        end
      end else begin
        x++;
      end
      px = x;
      py = y;
      pz = z;
    endfunction

    function void match_beat(logic [1:0] plane, logic [15:0] index, logic [31:0] value,
                             logic last);
      plane_beat_t want;
      if (pending_hits.size() == 0) begin
        report($sformatf("unexpected beat plane=%0d index=%0d value=%h last=%b",
                         plane, index, value, last));
        return;
      end
      want = pending_hits.pop_front();
      if (plane !== want.plane)
        report($sformatf("plane expected %0d got %0d", want.plane, plane));
      if (index !== want.index)
        report($sformatf("plane_index expected %0d got %0d", want.index, index));
      if (value !== want.value)
        report($sformatf("value_out expected %h got %h", want.value, value));
      if (last !== want.last)
        report($sformatf("last expected %b got %b", want.last, last));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [31:0]         voxel_bits_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [1:0]          plane_o;
  logic [15:0]         plane_index_o;
  logic [31:0]         value_out_o;
  logic                last_o;

  slice_tracker tracker = new();
  logic [31:0]  directed_bits[$];
  int unsigned  voxels_sent   = 0;
  int unsigned  hold_requests = 0;
  int unsigned  cycle_count   = 0;

  orthogonal_slice_extractor_unit #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .voxel_bits_i (voxel_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .plane_o      (plane_o),
    .plane_index_o(plane_index_o),
    .value_out_o  (value_out_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output side: checks beats, stalls at random, honors long hold requests
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        tracker.match_beat(plane_o, plane_index_o, value_out_o, last_o);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left--;
        end else if ($urandom_range(0, 149) == 0) begin
          quiet_left = $urandom_range(50, 150);
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = idle_len();
        end
      end
    end
  end

  function automatic logic [31:0] next_voxel();
    if (directed_bits.size() != 0) return directed_bits.pop_front();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FC0_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(257, 511));
      4:       return 9'($urandom_range(9, 255));
      default: return 9'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_slice(logic [8:0] dim);
    if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, tracker.span(dim) - 1));
  endfunction

  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so writes can go back to back
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  task automatic stream_voxels(int count, int pause_at);
    int unsigned gap;
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < count; k++) begin
      in_valid_i   <= 1'b1;
      voxel_bits_i <= next_voxel();
      do @(posedge clk_i); while (!in_ready_o);
      tracker.take_voxel(voxel_bits_i);
      voxels_sent++;
      gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (k == count - 1) begin
        in_valid_i <= 1'b0;
      end else if (k == pause_at) begin
        in_valid_i <= 1'b0;
        wait_idle();
      end else if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic random_phase(int phase_no);
    int count;
    int pause_at;
    if (phase_no == 1) begin
      // small dense volume with a long output hold so the pipeline backs up
      cfg_write(CFG_SIZE_X, 9'd3);
      cfg_write(CFG_SIZE_Y, 9'd3);
      cfg_write(CFG_SIZE_Z, 9'd3);
      cfg_write(CFG_SLICE_X, 9'd1);
      cfg_write(CFG_SLICE_Y, 9'd1);
      cfg_write(CFG_SLICE_Z, 9'd1);
      cfg_write(CFG_FLIP_MASK, 9'($urandom_range(0, 7)));
      hold_requests <= hold_requests + 1;
      count = 60;
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        cfg_write(CFG_SIZE_X, pick_size());
        cfg_write(CFG_SIZE_Y, pick_size());
        cfg_write(CFG_SIZE_Z, pick_size());
      end
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_SLICE_X, pick_slice(tracker.dim_x));
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_SLICE_Y, pick_slice(tracker.dim_y));
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_SLICE_Z, pick_slice(tracker.dim_z));
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_FLIP_MASK, 9'($urandom_range(0, 511)));
      if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNMAPPED, 9'($urandom_range(0, 511)));
      count = $urandom_range(10, 50);
    end
    cfg_valid_i <= 1'b0;
    pause_at = (phase_no == 3) ? count / 2 : -1;
    stream_voxels(count, pause_at);
    wait_idle();
  endtask

  initial begin
    int phase_no;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setup: the origin voxel sits on all three planes
    directed_bits = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    stream_voxels(3, -1);
    wait_idle();

    // clamped sizes, slice data with its top bit set, all flips, unmapped index
    cfg_write(CFG_SIZE_X, 9'd0);
    cfg_write(CFG_SIZE_Y, 9'd511);
    cfg_write(CFG_SIZE_Z, 9'd256);
    cfg_write(CFG_SLICE_X, 9'd0);
    cfg_write(CFG_SLICE_Y, 9'h101);
    cfg_write(CFG_SLICE_Z, 9'd0);
    cfg_write(CFG_FLIP_MASK, 9'd7);
    cfg_write(CFG_UNMAPPED, 9'h1FF);
    cfg_valid_i <= 1'b0;
    directed_bits = '{32'h7FFF_FFFF, 32'h0000_0001, 32'hFF80_0000, 32'h7F80_0000,
                      32'hA5A5_5A5A};
    stream_voxels(5, -1);
    wait_idle();

    // tiny volume walked through two full passes and into a third; z slice outside the volume
    cfg_write(CFG_SIZE_X, 9'd2);
    cfg_write(CFG_SIZE_Y, 9'd2);
    cfg_write(CFG_SIZE_Z, 9'd1);
    cfg_write(CFG_SLICE_X, 9'd1);
    cfg_write(CFG_SLICE_Y, 9'd1);
    cfg_write(CFG_SLICE_Z, 9'd255);
    cfg_write(CFG_FLIP_MASK, 9'h1F9);
    cfg_valid_i <= 1'b0;
    directed_bits = '{32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 32'h0F0F_F0F0,
                      32'hF0F0_0F0F, 32'h5555_AAAA, 32'hAAAA_5555, 32'h3F80_0000,
                      32'hBF80_0000};
    stream_voxels(9, -1);
    wait_idle();

    phase_no = 0;
    while (voxels_sent < TOTAL_VOXELS) begin
      random_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d expected beats never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[orthogonal_slice_extractor_unit.f]
+incdir+rtl/core
rtl/core/ose_pkg.sv
rtl/core/orthogonal_slice_extractor_unit.sv
bench/tb_orthogonal_slice_extractor_unit.sv
